### hdl/srtkf_pkg.sv
// types and constants shared by the sorted-run top-k frequency unit
// used by srtkf_cell, the top level and the port checker

package srtkf_pkg;

    localparam int KEY_W  = 64;   // column value width
    localparam int TOT_W  = 32;   // row and run totals, emitted counts
    localparam int RANK_W = 4;    // emitted rank field

    // list cell operations, broadcast to every cell
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_SHIFT  = 2'd2;

    // broadcast control for the cell row
    typedef struct packed {
        logic [1:0] op;
        logic       lt0;       // new count goes to position zero (list empty or below entry zero)
        logic       full;      // every cell holds an entry
        logic       full_top;  // full list, new count at least the last entry
        logic       full_mid;  // full list, new count strictly inside
    } t_cell_ctl;

    // status a cell shows to its neighbors
    typedef struct packed {
        logic is_end;  // no cell here, row boundary
        logic valid;   // cell holds an entry
        logic below;   // entry count below the new count
        logic above;   // entry count above the new count
        logic aa;      // cell lies at or after the insert position
    } t_cell_stat;

    localparam t_cell_stat END_STAT = '{is_end: 1'b1, valid: 1'b0, below: 1'b0,
                                        above: 1'b0, aa: 1'b0};

endpackage

### hdl/srtkf_cell.sv
// one entry of the ascending-count list: value, null flag, count, valid
// depends on srtkf_pkg; neighbors exchange status and entries every cycle

module srtkf_cell #(
    parameter int CNT_W = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  srtkf_pkg::t_cell_ctl      i_ctl,
    input  logic [srtkf_pkg::KEY_W-1:0] i_new_key,
    input  logic                      i_new_null,
    input  logic [CNT_W-1:0]          i_new_cnt,
    input  srtkf_pkg::t_cell_stat     i_left,
    input  logic [srtkf_pkg::KEY_W-1:0] i_left_key,
    input  logic                      i_left_null,
    input  logic [CNT_W-1:0]          i_left_cnt,
    input  srtkf_pkg::t_cell_stat     i_right,
    input  logic [srtkf_pkg::KEY_W-1:0] i_right_key,
    input  logic                      i_right_null,
    input  logic [CNT_W-1:0]          i_right_cnt,
    output srtkf_pkg::t_cell_stat     o_stat,
    output logic [srtkf_pkg::KEY_W-1:0] o_key,
    output logic                      o_null,
    output logic [CNT_W-1:0]          o_cnt
);
    import srtkf_pkg::*;

    localparam logic [1:0] SEL_HOLD  = 2'd0;
    localparam logic [1:0] SEL_NEW   = 2'd1;
    localparam logic [1:0] SEL_LEFT  = 2'd2;
    localparam logic [1:0] SEL_RIGHT = 2'd3;

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic             r_null;
    logic [CNT_W-1:0] r_cnt;

    logic             n_valid;
    logic [1:0]       w_sel;
    logic             w_below;
    logic             w_above;
    logic             w_aa;

    assign w_below = r_valid && (r_cnt < i_new_cnt);
    assign w_above = r_valid && (r_cnt > i_new_cnt);
    assign w_aa    = i_ctl.lt0 || (!i_left.is_end && !w_below);

    always_comb begin
        w_sel   = SEL_HOLD;
        n_valid = r_valid;
        case (i_ctl.op)
            OP_INSERT: begin
                if (!i_ctl.full) begin
                    if (w_aa && !i_left.aa) begin
                        w_sel = SEL_NEW;
                    end else if (i_left.aa && i_left.valid) begin
                        w_sel = SEL_LEFT;
                    end
                    n_valid = r_valid || i_left.is_end || i_left.valid;
                end else if (i_ctl.full_top) begin
                    w_sel = i_right.is_end ? SEL_NEW : SEL_RIGHT;
                end else if (i_ctl.full_mid) begin
                    if (!i_right.is_end && i_right.below) begin
                        w_sel = SEL_RIGHT;
                    end else if (i_left.is_end || w_below) begin
                        w_sel = SEL_NEW;
                    end
                end
            end
            OP_SHIFT: begin
                w_sel   = SEL_RIGHT;
                n_valid = i_right.valid;
            end
            default: begin
                w_sel = SEL_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        case (w_sel)
            SEL_NEW: begin
                r_key <= i_new_key;
                r_null <= i_new_null;
                r_cnt <= i_new_cnt;
            end
            SEL_LEFT: begin
                r_key <= i_left_key;
                r_null <= i_left_null;
                r_cnt <= i_left_cnt;
            end
            SEL_RIGHT: begin
                r_key <= i_right_key;
                r_null <= i_right_null;
                r_cnt <= i_right_cnt;
            end
            default: begin
                r_key <= r_key;
            end
        endcase
    end

    assign o_stat = '{is_end: 1'b0, valid: r_valid, below: w_below,
                      above: w_above, aa: w_aa};
    assign o_key  = r_key;
    assign o_null = r_null;
    assign o_cnt  = r_cnt;

endmodule

### hdl/sorted_run_top_k_frequency_unit.sv
// top level of the sorted-run top-k frequency unit: run tracking, totals, sequencer
// depends on srtkf_pkg and a row of srtkf_cell instances

// Rows of an already sorted column come in one per cycle (valid/ready); equal
// neighboring rows (null equals only null) form a run, and each run that closes
// is inserted into a row of LIST_DEPTH cells kept in ascending count order, one
// insertion per cycle, every cell comparing its own count with the new one in
// parallel and taking the new entry or its neighbor's. After the row carrying
// last_row is taken, the flush state inserts the final run, and then one result
// item per kept entry is shown, smallest count first, shifted out of cell zero:
// LIST_DEPTH at most, each waiting for the output ready. No row is accepted
// from the last row until the final result item is taken; after it the unit
// is back in its reset state, apart from the rank.
// Run lengths saturate at COUNT_BITS bits, totals and emitted counts at 32.

module sorted_run_top_k_frequency_unit #(
    parameter int LIST_DEPTH = 10,
    parameter int COUNT_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // row channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [srtkf_pkg::KEY_W-1:0]   i_value,
    input  logic                          i_value_is_null,
    input  logic                          i_last_row,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [srtkf_pkg::RANK_W-1:0]  o_rank,
    output logic [srtkf_pkg::KEY_W-1:0]   o_entry_value,
    output logic                          o_entry_is_null,
    output logic [srtkf_pkg::TOT_W-1:0]   o_entry_count,
    output logic [srtkf_pkg::TOT_W-1:0]   o_total_rows,
    output logic [srtkf_pkg::TOT_W-1:0]   o_distinct_runs,
    output logic [srtkf_pkg::KEY_W-1:0]   o_minimum,
    output logic                          o_minimum_is_null,
    output logic [srtkf_pkg::KEY_W-1:0]   o_maximum,
    output logic                          o_maximum_is_null,
    output logic                          o_final_entry
);
    import srtkf_pkg::*;

    localparam int RW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    // sequencer states
    localparam logic [1:0] S_RUN   = 2'd0;  // taking rows
    localparam logic [1:0] S_FLUSH = 2'd1;  // inserting the final run
    localparam logic [1:0] S_EMIT  = 2'd2;  // shifting results out of cell zero

    logic [1:0]            r_state, n_state;
    logic [KEY_W-1:0]      r_run_key, n_run_key;
    logic                  r_run_null, n_run_null;
    logic [COUNT_BITS-1:0] r_run_len, n_run_len;
    logic [KEY_W-1:0]      r_prev_key, n_prev_key;
    logic                  r_prev_null, n_prev_null;
    logic [TOT_W-1:0]      r_row_total, n_row_total;
    logic [TOT_W-1:0]      r_run_total, n_run_total;
    logic [KEY_W-1:0]      r_min_key, n_min_key;
    logic                  r_min_null, n_min_null;
    logic                  r_seen_first, n_seen_first;
    logic [KEY_W-1:0]      r_max_key, n_max_key;
    logic                  r_max_null, n_max_null;
    logic [RW-1:0]         r_rank, n_rank;

    // cell row wiring
    t_cell_stat            w_stat [LIST_DEPTH];
    logic [KEY_W-1:0]      w_key  [LIST_DEPTH];
    logic                  w_null [LIST_DEPTH];
    logic [COUNT_BITS-1:0] w_cnt  [LIST_DEPTH];
    t_cell_ctl             w_ctl;

    logic             w_in_acc;
    logic             w_out_acc;
    logic [KEY_W-1:0] w_val;     // null rows hold value zero
    logic             w_same;    // row continues the open run
    logic             w_mx_prev; // last run null with more than one kept entry

    assign o_ready   = (r_state == S_RUN);
    assign o_valid   = (r_state == S_EMIT);
    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;

    assign w_val  = i_value_is_null ? '0 : i_value;
    assign w_same = (i_value_is_null == r_run_null) && (w_val == r_run_key);

    // after the final insertion the list holds more than one entry exactly
    // when entry zero is already occupied
    assign w_mx_prev = w_stat[0].valid && r_run_null;

    // cell row control: the entry to insert is always the open run
    always_comb begin
        w_ctl.op = OP_HOLD;
        case (r_state)
            S_RUN: begin
                if (w_in_acc && r_seen_first && !w_same) begin
                    w_ctl.op = OP_INSERT;  // a run closes
                end
            end
            S_FLUSH: begin
                w_ctl.op = OP_INSERT;
            end
            S_EMIT: begin
                if (w_out_acc) begin
                    w_ctl.op = OP_SHIFT;
                end
            end
            default: begin
                w_ctl.op = OP_HOLD;
            end
        endcase
        w_ctl.lt0      = !w_stat[0].valid || w_stat[0].above;
        w_ctl.full     = w_stat[LIST_DEPTH-1].valid;
        w_ctl.full_top = w_stat[LIST_DEPTH-1].valid && !w_stat[LIST_DEPTH-1].above;
        w_ctl.full_mid = w_stat[LIST_DEPTH-1].valid && w_stat[LIST_DEPTH-1].above
                         && w_stat[0].below;
    end

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
            t_cell_stat            w_l_stat, w_r_stat;
            logic [KEY_W-1:0]      w_l_key, w_r_key;
            logic                  w_l_null, w_r_null;
            logic [COUNT_BITS-1:0] w_l_cnt, w_r_cnt;

            if (gi == 0) begin : g_left_end
                assign w_l_stat = END_STAT;
                assign w_l_key  = '0;
                assign w_l_null = 1'b0;
                assign w_l_cnt  = '0;
            end else begin : g_left
                assign w_l_stat = w_stat[gi-1];
                assign w_l_key  = w_key[gi-1];
                assign w_l_null = w_null[gi-1];
                assign w_l_cnt  = w_cnt[gi-1];
            end

            if (gi == LIST_DEPTH - 1) begin : g_right_end
                assign w_r_stat = END_STAT;
                assign w_r_key  = '0;
                assign w_r_null = 1'b0;
                assign w_r_cnt  = '0;
            end else begin : g_right
                assign w_r_stat = w_stat[gi+1];
                assign w_r_key  = w_key[gi+1];
                assign w_r_null = w_null[gi+1];
                assign w_r_cnt  = w_cnt[gi+1];
            end

            srtkf_cell #(
                .CNT_W (COUNT_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_new_key    (r_run_key),
                .i_new_null   (r_run_null),
                .i_new_cnt    (r_run_len),
                .i_left       (w_l_stat),
                .i_left_key   (w_l_key),
                .i_left_null  (w_l_null),
                .i_left_cnt   (w_l_cnt),
                .i_right      (w_r_stat),
                .i_right_key  (w_r_key),
                .i_right_null (w_r_null),
                .i_right_cnt  (w_r_cnt),
                .o_stat       (w_stat[gi]),
                .o_key        (w_key[gi]),
                .o_null       (w_null[gi]),
                .o_cnt        (w_cnt[gi])
            );
        end
    endgenerate

    // run tracking, totals and sequencing
    always_comb begin
        n_state      = r_state;
        n_run_key    = r_run_key;
        n_run_null   = r_run_null;
        n_run_len    = r_run_len;
        n_prev_key   = r_prev_key;
        n_prev_null  = r_prev_null;
        n_row_total  = r_row_total;
        n_run_total  = r_run_total;
        n_min_key    = r_min_key;
        n_min_null   = r_min_null;
        n_seen_first = r_seen_first;
        n_max_key    = r_max_key;
        n_max_null   = r_max_null;
        n_rank       = r_rank;
        case (r_state)
            S_RUN: begin
                if (w_in_acc) begin
                    if (!r_seen_first) begin
                        // first row opens the first run and fixes the minimum
                        n_seen_first = 1'b1;
                        n_min_key    = w_val;
                        n_min_null   = i_value_is_null;
                        n_run_key    = w_val;
                        n_run_null   = i_value_is_null;
                        n_run_len    = COUNT_BITS'(1);
                        n_row_total  = TOT_W'(1);
                    end else begin
                        if (r_row_total != '1) begin
                            n_row_total = r_row_total + 1'b1;
                        end
                        if (w_same) begin
                            if (r_run_len != '1) begin
                                n_run_len = r_run_len + 1'b1;
                            end
                        end else begin
                            // open run goes into the list this cycle
                            if (r_run_total != '1) begin
                                n_run_total = r_run_total + 1'b1;
                            end
                            n_prev_key  = r_run_key;
                            n_prev_null = r_run_null;
                            n_run_key   = w_val;
                            n_run_null  = i_value_is_null;
                            n_run_len   = COUNT_BITS'(1);
                        end
                    end
                    if (i_last_row) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (r_run_total != '1) begin
                    n_run_total = r_run_total + 1'b1;
                end
                n_max_null = w_mx_prev ? r_prev_null : r_run_null;
                if (n_max_null) begin
                    n_max_key = '0;
                end else begin
                    n_max_key = w_mx_prev ? r_prev_key : r_run_key;
                end
                n_rank  = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_acc) begin
                    n_rank = r_rank + 1'b1;
                    if (o_final_entry) begin
                        // back to the reset state, rank apart; this last shift empties the cells
                        n_state      = S_RUN;
                        n_run_key    = '0;
                        n_run_null   = 1'b0;
                        n_run_len    = '0;
                        n_prev_key   = '0;
                        n_prev_null  = 1'b1;
                        n_row_total  = '0;
                        n_run_total  = '0;
                        n_min_key    = '0;
                        n_min_null   = 1'b1;
                        n_seen_first = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_RUN;
            r_run_key    <= '0;
            r_run_null   <= 1'b0;
            r_run_len    <= '0;
            r_prev_key   <= '0;
            r_prev_null  <= 1'b1;
            r_row_total  <= '0;
            r_run_total  <= '0;
            r_min_key    <= '0;
            r_min_null   <= 1'b1;
            r_seen_first <= 1'b0;
            r_rank       <= '0;
        end else begin
            r_state      <= n_state;
            r_run_key    <= n_run_key;
            r_run_null   <= n_run_null;
            r_run_len    <= n_run_len;
            r_prev_key   <= n_prev_key;
            r_prev_null  <= n_prev_null;
            r_row_total  <= n_row_total;
            r_run_total  <= n_run_total;
            r_min_key    <= n_min_key;
            r_min_null   <= n_min_null;
            r_seen_first <= n_seen_first;
            r_rank       <= n_rank;
        end
    end

    // maximum is payload, written in the flush cycle before it is shown
    always_ff @(posedge i_clk) begin
        r_max_key  <= n_max_key;
        r_max_null <= n_max_null;
    end

    // result item comes straight from cell zero
    assign o_rank            = RANK_W'(r_rank);
    assign o_entry_value     = w_null[0] ? '0 : w_key[0];
    assign o_entry_is_null   = w_null[0];
    assign o_total_rows      = r_row_total;
    assign o_distinct_runs   = r_run_total;
    assign o_minimum         = r_min_null ? '0 : r_min_key;
    assign o_minimum_is_null = r_min_null;
    assign o_maximum         = r_max_key;
    assign o_maximum_is_null = r_max_null;
    assign o_final_entry     = !w_stat[1].valid;

    // emitted count saturates at the result width
    generate
        if (COUNT_BITS > TOT_W) begin : g_cnt_sat
            assign o_entry_count = (|w_cnt[0][COUNT_BITS-1:TOT_W]) ? '1
                                   : w_cnt[0][TOT_W-1:0];
        end else begin : g_cnt_ext
            assign o_entry_count = TOT_W'(w_cnt[0]);
        end
    endgenerate

endmodule

### hdl/srtkf_checker.sv
// port-level checks for the sorted-run top-k frequency unit
// depends on srtkf_pkg; bound to the top level at the end of this file

module srtkf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         i_last_row,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [srtkf_pkg::RANK_W-1:0] o_rank,
    input logic                         o_final_entry
);
    import srtkf_pkg::*;

    // no row is taken while results are being shown
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("row channel ready while results shown");

    // the last row is followed by the flush cycle, no row taken
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last_row) |=> (!o_ready && !o_valid))
        else $error("row taken right after the last row");

    // results keep coming, ranks rising by one, until the final one
    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_final_entry) |=>
            (o_valid && (o_rank == $past(o_rank) + 1'b1)))
        else $error("result burst broken or rank skipped");

    // the final result ends the burst and rows are taken again
    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_final_entry) |=> (!o_valid && o_ready))
        else $error("results continue after the final item");

endmodule

bind sorted_run_top_k_frequency_unit srtkf_checker u_srtkf_checker (.*);
